[rtl/pfd_pkg.sv]
`default_nettype none
package pfd_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int LINE_DEPTH = 256;
  localparam int FRAME_ROWS = 192;
  localparam int LETTERBOX = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    MODE_FIT   = 3'd0,
    MODE_BLEND = 3'd1,
    MODE_FILL  = 3'd2,
    MODE_CROP  = 3'd3,
    MODE_VFIT  = 3'd4,
    MODE_VCROP = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_PAN_X  = 3'd1,
    REG_PAN_Y  = 3'd2,
    REG_VIEW_X = 3'd3,
    REG_VIEW_Y = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_PALETTE = 1'b0,
    REQ_PIXEL   = 1'b1
  } req_t;

  typedef struct packed {
    logic        is_wr;
    logic [7:0]  idx;
    logic [15:0] ecol;
    logic [7:0]  x;
    logic        x_odd;
    logic        y_odd;
    logic        hit;
    logic        blend;
    logic [6:0]  dx;
    logic [6:0]  dy;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] d;
  } map_t;

endpackage
`default_nettype wire

[rtl/pfd_if.sv]
`default_nettype none
interface pfd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  src_x;
  logic [7:0]  src_y;
  logic [7:0]  pixel_index;
  logic [15:0] entry_color;
  modport source (output valid, req_type, src_x, src_y, pixel_index, entry_color,
                  input ready);
  modport sink (input valid, req_type, src_x, src_y, pixel_index, entry_color,
                output ready);
endinterface

interface pfd_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  dst_x;
  logic [6:0]  dst_y;
  logic [15:0] color_out;
  modport source (output valid, dst_x, dst_y, color_out, input ready);
  modport sink (input valid, dst_x, dst_y, color_out, output ready);
endinterface

interface pfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/pfd_fifo.sv]
`default_nettype none
module pfd_fifo
  import pfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire job_t       push_job,
  input  wire logic       pop,
  output job_t            pop_job,
  output fifo_stat_t      stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign pop_job    = slots[rd_ptr];
  assign stat.full  = (count == (AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/pfd_front.sv]
`default_nettype none
module pfd_front
  import pfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  pfd_in_if.sink     src,
  pfd_cfg_if.sink    cfg,
  input  wire logic  q_full,
  output logic       push,
  output job_t       job
);

  logic [2:0] mode_sel;
  logic [7:0] pan_x;
  logic [7:0] pan_y;
  logic [6:0] view_x;
  logic [5:0] view_y;

  // ceil(2s/3), hit when (c*3)/2 == s
  function automatic map_t inv32(input logic [7:0] s);
    logic [9:0]  v;
    logic [19:0] p;
    logic [7:0]  c;
    logic [9:0]  c3;
    map_t        m;
    v    = {1'b0, s, 1'b0} + 10'd2;
    p    = 20'(v) * 20'd683;
    c    = p[18:11];
    c3   = {1'b0, c, 1'b0} + {2'b0, c};
    m.ok = !c[7] && (c3[8:1] == s);
    m.d  = c[6:0];
    return m;
  endfunction

  function automatic map_t inv54(input logic [7:0] s);
    logic [10:0] v;
    logic [22:0] p;
    logic [7:0]  c;
    logic [10:0] c5;
    map_t        m;
    v    = {1'b0, s, 2'b0} + 11'd4;
    p    = 23'(v) * 23'd3277;
    c    = p[21:14];
    c5   = {1'b0, c, 2'b0} + {3'b0, c};
    m.ok = !c[7] && (c5[9:2] == s) && !c5[10];
    m.d  = c[6:0];
    return m;
  endfunction

  function automatic map_t inv98(input logic [7:0] s);
    logic [11:0] v;
    logic [24:0] p;
    logic [7:0]  c;
    logic [11:0] c9;
    map_t        m;
    v    = {1'b0, s, 3'b0} + 12'd8;
    p    = 25'(v) * 25'd7282;
    c    = p[23:16];
    c9   = {1'b0, c, 3'b0} + {4'b0, c};
    m.ok = !c[7] && (c9[10:3] == s) && !c9[11];
    m.d  = c[6:0];
    return m;
  endfunction

  // window test: p <= x < p + 128
  function automatic map_t win(input logic [7:0] x, input logic [7:0] p);
    logic [8:0] diff;
    map_t       m;
    diff = {1'b0, x} - {1'b0, p};
    m.ok = !diff[8] && !diff[7];
    m.d  = diff[6:0];
    return m;
  endfunction

  logic       in_frame;
  logic       hit;
  logic [6:0] dx;
  logic [6:0] dy;
  logic [7:0] px;
  logic [7:0] py;
  logic [7:0] sx;
  logic [7:0] sy;
  map_t       mx;
  map_t       my;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel <= MODE_FIT;
      pan_x    <= 8'd64;
      pan_y    <= 8'd32;
      view_x   <= 7'd48;
      view_y   <= 6'd24;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_MODE:   mode_sel <= cfg.data[2:0];
        REG_PAN_X:  pan_x    <= cfg.data;
        REG_PAN_Y:  pan_y    <= cfg.data;
        REG_VIEW_X: view_x   <= cfg.data[6:0];
        REG_VIEW_Y: view_y   <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hit = 1'b0;
    dx  = src.src_x[7:1];
    dy  = 7'(LETTERBOX) + src.src_y[7:1];
    px  = '0;
    py  = '0;
    sx  = '0;
    sy  = '0;
    mx  = '0;
    my  = '0;
    case (mode_t'(mode_sel))
      MODE_FIT: begin
        hit = !src.src_x[0] && !src.src_y[0];
      end
      MODE_BLEND: begin
        hit = src.src_x[0] && src.src_y[0];
      end
      MODE_FILL: begin
        sx  = src.src_x - 8'd32;
        mx  = inv32(sx);
        my  = inv32(src.src_y);
        hit = (src.src_x >= 8'd32) && (src.src_x < 8'd224) && mx.ok && my.ok;
        dx  = mx.d;
        dy  = my.d;
      end
      MODE_CROP: begin
        px  = (pan_x > 8'd128) ? 8'd128 : pan_x;
        py  = (pan_y > 8'd64) ? 8'd64 : pan_y;
        mx  = win(src.src_x, px);
        my  = win(src.src_y, py);
        hit = mx.ok && my.ok;
        dx  = mx.d;
        dy  = my.d;
      end
      MODE_VFIT: begin
        sx  = src.src_x - {1'b0, view_x};
        sy  = src.src_y - {2'b0, view_y};
        mx  = inv54(sx);
        my  = inv98(sy);
        hit = (src.src_x >= {1'b0, view_x}) && (src.src_y >= {2'b0, view_y})
              && mx.ok && my.ok;
        dx  = mx.d;
        dy  = my.d;
      end
      MODE_VCROP: begin
        px  = {1'b0, view_x} + ((pan_x > 8'd32) ? 8'd32 : pan_x);
        py  = {2'b0, view_y} + ((pan_y > 8'd16) ? 8'd16 : pan_y);
        mx  = win(src.src_x, px);
        my  = win(src.src_y, py);
        hit = mx.ok && my.ok;
        dx  = mx.d;
        dy  = my.d;
      end
      default: hit = 1'b0;
    endcase
  end

  assign in_frame  = (src.src_y < 8'(FRAME_ROWS));
  assign src.ready = !q_full;
  assign push      = src.valid && !q_full
                     && ((req_t'(src.req_type) == REQ_PALETTE) || in_frame);

  assign job.is_wr = (req_t'(src.req_type) == REQ_PALETTE);
  assign job.idx   = src.pixel_index;
  assign job.ecol  = src.entry_color;
  assign job.x     = src.src_x;
  assign job.x_odd = src.src_x[0];
  assign job.y_odd = src.src_y[0];
  assign job.hit   = hit;
  assign job.blend = (mode_t'(mode_sel) == MODE_BLEND);
  assign job.dx    = dx;
  assign job.dy    = dy;

endmodule
`default_nettype wire

[rtl/pfd_back.sv]
`default_nettype none
module pfd_back
  import pfd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire job_t  q_job,
  output logic       pop,
  pfd_out_if.source  dst
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int LS_AW  = $clog2(LINE_DEPTH);

  function automatic logic [15:0] blend4(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d);
    logic [6:0] r;
    logic [7:0] g;
    logic [6:0] bl;
    r  = 7'(a[15:11]) + 7'(b[15:11]) + 7'(c[15:11]) + 7'(d[15:11]);
    g  = 8'(a[10:5]) + 8'(b[10:5]) + 8'(c[10:5]) + 8'(d[10:5]);
    bl = 7'(a[4:0]) + 7'(b[4:0]) + 7'(c[4:0]) + 7'(d[4:0]);
    return {r[6:2], g[7:2], bl[6:2]};
  endfunction

  logic [15:0] palette [PALETTE_ENTRIES];
  logic [15:0] line_buf [LINE_DEPTH];

  logic        en;
  logic        idx_ok;

  logic        s2_valid;
  job_t        s2_job;
  logic        s2_oor;
  logic [15:0] pal_q;
  logic [15:0] col2;

  logic        s3_valid;
  job_t        s3_job;
  logic [15:0] col3;
  logic [15:0] left3;
  logic [15:0] ls_a;
  logic [15:0] ls_b;

  logic [15:0] left_pixel;

  assign en     = !dst.valid || dst.ready;
  assign pop    = en && !q_empty;
  assign idx_ok = ({1'b0, q_job.idx} < 9'(PALETTE_ENTRIES));
  assign col2   = s2_oor ? 16'd0 : pal_q;

  // palette write or lookup
  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_job.is_wr) begin
        if (idx_ok) palette[q_job.idx[PAL_AW-1:0]] <= q_job.ecol;
      end else begin
        pal_q <= palette[q_job.idx[PAL_AW-1:0]];
      end
      s2_job <= q_job;
      s2_oor <= !idx_ok;
    end
  end

  // line store and neighbor reads
  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      if (!s2_job.y_odd) line_buf[s2_job.x[LS_AW-1:0]] <= col2;
      ls_a   <= line_buf[LS_AW'(s2_job.x - 8'd1)];
      ls_b   <= line_buf[s2_job.x[LS_AW-1:0]];
      s3_job <= s2_job;
      col3   <= col2;
      left3  <= left_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid && s3_job.hit) begin
      dst.dst_x     <= s3_job.dx;
      dst.dst_y     <= s3_job.dy;
      dst.color_out <= s3_job.blend ? blend4(ls_a, ls_b, left3, col3) : col3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      dst.valid  <= 1'b0;
      left_pixel <= '0;
    end else if (en) begin
      s2_valid  <= pop && !q_job.is_wr;
      s3_valid  <= s2_valid;
      dst.valid <= s3_valid && s3_job.hit;
      if (s2_valid && s2_job.y_odd && !s2_job.x_odd) left_pixel <= col2;
    end
  end

endmodule
`default_nettype wire

[rtl/palette_frame_downscaler.sv]
`default_nettype none
// Palette frame downscaler: maps 256x192 palette-indexed source pixels (and palette
// writes) on src to RGB565 pixels of a 128x128 destination on dst, in one of six scale
// modes set through cfg. One item is taken per clock when dst keeps up; a pixel result
// passes from front decode into a four-entry queue, then through palette read, line-store
// read and the blend/output register. Back-pressure on dst stalls the back end; src keeps
// taking items until the queue fills.
module palette_frame_downscaler
  import pfd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pfd_in_if.sink    src,
  pfd_cfg_if.sink   cfg,
  pfd_out_if.source dst
);

  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       pop_job;
  fifo_stat_t q_stat;

  pfd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .src    (src),
    .cfg    (cfg),
    .q_full (q_stat.full),
    .push   (push),
    .job    (push_job)
  );

  pfd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  pfd_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_stat.empty),
    .q_job   (pop_job),
    .pop     (pop),
    .dst     (dst)
  );

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty)) else $error("queue full and empty");
  a_reset_out: assert property (@(posedge clk) rst |=> !dst.valid)
    else $error("result valid after reset");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none
module tb
  import pfd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    req_t        kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  idx;
    logic [15:0] ecol;
  } src_item_t;

  typedef struct {
    logic [6:0]  dx;
    logic [6:0]  dy;
    logic [15:0] color;
  } dst_pix_t;

  typedef enum int { CHK_MODEL, CHK_NONE, CHK_PIX } chk_t;

  typedef struct {
    src_item_t item;
    chk_t      chk;
    dst_pix_t  pix;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  pfd_in_if  src_if ();
  pfd_cfg_if cfg_if ();
  pfd_out_if dst_if ();

  palette_frame_downscaler u_dut (
    .clk (clk),
    .rst (rst),
    .src (src_if.sink),
    .cfg (cfg_if.sink),
    .dst (dst_if.source)
  );

  always #6 clk = ~clk;

  // shadow state of the block
  logic [15:0] pal_mem [256];
  logic [15:0] row_colors [256];
  logic [15:0] left_color;
  logic [2:0]  mode_reg;
  logic [7:0]  pan_x_reg, pan_y_reg;
  logic [6:0]  view_x_reg;
  logic [5:0]  view_y_reg;

  dst_pix_t pending_pix[$];
  int errors = 0;
  int pix_seen = 0;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [15:0] avg565(logic [15:0] a, logic [15:0] b,
                                         logic [15:0] c, logic [15:0] d);
    int r, g, bl;
    r = a[15:11] + b[15:11] + c[15:11] + d[15:11];
    g = a[10:5] + b[10:5] + c[10:5] + d[10:5];
    bl = a[4:0] + b[4:0] + c[4:0] + d[4:0];
    return {r[6:2], g[7:2], bl[6:2]};
  endfunction

  // destination coordinate that samples source coordinate s under d*num/den
  function automatic bit back_map(int s, int num, int den, output int d);
    int c;
    c = (s * den + num - 1) / num;
    d = c;
    return (c < 128) && ((c * num) / den == s);
  endfunction

  function automatic bit predict_pixel(src_item_t it, output dst_pix_t pix);
    int x, y, dx, dy, px, py;
    bit hit, okx, oky;
    logic [15:0] col;
    x = it.x; y = it.y; dx = 0; dy = 0; hit = 0;
    pix = '{0, 0, 0};
    if (it.kind == REQ_PALETTE) begin
      pal_mem[it.idx] = it.ecol;
      return 0;
    end
    if (y >= FRAME_ROWS) return 0;
    col = pal_mem[it.idx];
    pix.color = col;
    case (mode_reg)
      MODE_FIT: if (x % 2 == 0 && y % 2 == 0) begin
        dx = x / 2; dy = LETTERBOX + y / 2; hit = 1;
      end
      MODE_BLEND: if (x % 2 == 1 && y % 2 == 1) begin
        pix.color = avg565(row_colors[x - 1], row_colors[x], left_color, col);
        dx = x / 2; dy = LETTERBOX + y / 2; hit = 1;
      end
      MODE_FILL: if (x >= 32 && x < 224) begin
        okx = back_map(x - 32, 3, 2, dx);
        oky = back_map(y, 3, 2, dy);
        hit = okx && oky;
      end
      MODE_CROP: begin
        px = pan_x_reg > 128 ? 128 : pan_x_reg;
        py = pan_y_reg > 64 ? 64 : pan_y_reg;
        if (x >= px && x - px < 128 && y >= py && y - py < 128) begin
          dx = x - px; dy = y - py; hit = 1;
        end
      end
      MODE_VFIT: if (x >= view_x_reg && y >= view_y_reg) begin
        okx = back_map(x - view_x_reg, 5, 4, dx);
        oky = back_map(y - view_y_reg, 9, 8, dy);
        hit = okx && oky;
      end
      MODE_VCROP: begin
        px = view_x_reg + (pan_x_reg > 32 ? 32 : pan_x_reg);
        py = view_y_reg + (pan_y_reg > 16 ? 16 : pan_y_reg);
        if (x >= px && x - px < 128 && y >= py && y - py < 128) begin
          dx = x - px; dy = y - py; hit = 1;
        end
      end
      default: hit = 0;
    endcase
    if (y % 2 == 0) row_colors[x] = col;
    else if (x % 2 == 0) left_color = col;
    pix.dx = dx[6:0];
    pix.dy = dy[6:0];
    return hit;
  endfunction

  task automatic send_item(src_item_t it, chk_t chk, dst_pix_t typed);
    dst_pix_t pix;
    bit hit;
    src_if.valid <= 1'b1;
    src_if.req_type <= it.kind;
    src_if.src_x <= it.x;
    src_if.src_y <= it.y;
    src_if.pixel_index <= it.idx;
    src_if.entry_color <= it.ecol;
    do @(posedge clk); while (!src_if.ready);
    hit = predict_pixel(it, pix);
    if (chk == CHK_PIX) pending_pix.push_back(typed);
    else if (chk == CHK_MODEL && hit) pending_pix.push_back(pix);
  endtask

  task automatic send_gap(bit no_gaps);
    int r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      src_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random(src_item_t it, bit no_gaps);
    send_item(it, CHK_MODEL, '{0, 0, 0});
    send_gap(no_gaps);
  endtask

  task automatic cfg_write(cfg_reg_t reg_idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= reg_idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (reg_idx)
      REG_MODE:   mode_reg = val[2:0];
      REG_PAN_X:  pan_x_reg = val;
      REG_PAN_Y:  pan_y_reg = val;
      REG_VIEW_X: view_x_reg = val[6:0];
      REG_VIEW_Y: view_y_reg = val[5:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    src_if.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(int m, int pxv, int pyv, int vxv, int vyv);
    wait_idle();
    cfg_write(REG_MODE, m[7:0]);
    cfg_write(REG_PAN_X, pxv[7:0]);
    cfg_write(REG_PAN_Y, pyv[7:0]);
    cfg_write(REG_VIEW_X, vxv[7:0]);
    cfg_write(REG_VIEW_Y, vyv[7:0]);
  endtask

  // mostly pairs of row segments in raster order, some palette writes and noise
  task automatic random_phase(int count);
    src_item_t it;
    int sent, r, y0, x0, len;
    bit no_gaps;
    sent = 0;
    no_gaps = ($urandom_range(0, 2) == 0);
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        it = '{REQ_PALETTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
        send_random(it, no_gaps);
        sent++;
      end else if (r < 15) begin
        it = '{REQ_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(192, 255)),
               8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
        send_random(it, no_gaps);
      end else begin
        y0 = 2 * $urandom_range(0, 95);
        x0 = $urandom_range(0, 254);
        len = $urandom_range(2, 16);
        if (x0 + len > 256) len = 256 - x0;
        for (int row = 0; row < 2; row++)
          for (int k = 0; k < len; k++) begin
            it = '{REQ_PIXEL, 8'(x0 + k), 8'(y0 + row), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535))};
            send_random(it, no_gaps);
            sent++;
          end
      end
    end
  endtask

  dir_row_t dir_rows [12];

  initial begin
    src_item_t it;
    rst <= 1'b1;
    src_if.valid <= 1'b0;
    src_if.req_type <= REQ_PALETTE;
    src_if.src_x <= '0;
    src_if.src_y <= '0;
    src_if.pixel_index <= '0;
    src_if.entry_color <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_MODE;
    cfg_if.data <= '0;
    mode_reg = MODE_FIT;
    pan_x_reg = 8'd64;
    pan_y_reg = 8'd32;
    view_x_reg = 7'd48;
    view_y_reg = 6'd24;
    left_color = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    foreach (row_colors[i]) row_colors[i] = '0;

    dir_rows = '{
      '{'{REQ_PALETTE, 8'd0, 8'd0, 8'd0, 16'h0000}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PALETTE, 8'd0, 8'd0, 8'd255, 16'hFFFF}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PALETTE, 8'd0, 8'd0, 8'd1, 16'hF800}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PIXEL, 8'd0, 8'd0, 8'd0, 16'hFFFF}, CHK_PIX, '{7'd0, 7'd16, 16'h0000}},
      '{'{REQ_PIXEL, 8'd1, 8'd0, 8'd255, 16'h0000}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PIXEL, 8'd254, 8'd0, 8'd255, 16'h0000}, CHK_PIX,
        '{7'd127, 7'd16, 16'hFFFF}},
      '{'{REQ_PIXEL, 8'd255, 8'd0, 8'd1, 16'h0000}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PIXEL, 8'd0, 8'd190, 8'd1, 16'h0000}, CHK_PIX,
        '{7'd0, 7'd111, 16'hF800}},
      '{'{REQ_PIXEL, 8'd255, 8'd191, 8'd255, 16'h0000}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PIXEL, 8'd0, 8'd192, 8'd0, 16'h0000}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PIXEL, 8'd255, 8'd255, 8'd255, 16'hFFFF}, CHK_NONE, '{0, 0, 0}},
      '{'{REQ_PIXEL, 8'd128, 8'd64, 8'd1, 16'h0000}, CHK_MODEL, '{0, 0, 0}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].pix);
      send_gap(1'b0);
    end

    // fill every palette entry and one full even row so later reads hit written data
    for (int i = 0; i < 256; i++) begin
      it = '{REQ_PALETTE, 8'd0, 8'd0, 8'(i), 16'($urandom_range(0, 65535))};
      send_random(it, 1'b1);
    end
    for (int i = 0; i < 256; i++) begin
      it = '{REQ_PIXEL, 8'(i), 8'd2, 8'($urandom_range(0, 255)), 16'h0000};
      send_random(it, 1'b0);
    end

    set_regs(MODE_FIT, 64, 32, 48, 24);
    random_phase(10);
    set_regs(MODE_BLEND, 0, 0, 0, 0);
    random_phase(14);
    set_regs(MODE_FILL, 255, 255, 96, 48);
    random_phase(10);
    set_regs(MODE_CROP, 0, 0, 0, 0);
    random_phase(8);
    set_regs(MODE_CROP, 255, 255, 96, 48);
    random_phase(8);
    set_regs(MODE_CROP, 100, 50, 0, 0);
    random_phase(8);
    set_regs(MODE_VFIT, 0, 0, 0, 0);
    random_phase(8);
    set_regs(MODE_VFIT, 128, 64, 96, 48);
    random_phase(8);
    set_regs(MODE_VFIT, 0, 0, 127, 63);
    random_phase(8);
    set_regs(MODE_VCROP, 0, 0, 96, 48);
    random_phase(8);
    set_regs(MODE_VCROP, 255, 255, 0, 0);
    random_phase(8);
    set_regs(MODE_VCROP, 20, 10, 127, 63);
    random_phase(8);
    set_regs(6, 1, 2, 3, 4);
    random_phase(6);
    set_regs(7, 5, 6, 7, 8);
    random_phase(6);
    for (int p = 0; p < 4; p++) begin
      set_regs($urandom_range(0, 5), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 96), $urandom_range(0, 48));
      random_phase(8);
    end

    wait_idle();
    if (errors == 0) begin
      $display("palette_frame_downscaler test passed");
    end else begin
      $display("palette_frame_downscaler test failed");
    end
    $finish;
  end

  // result side: random back-pressure and one long hold-off
  int hold_left = 0;
  bit long_hold_done = 0;

  always @(posedge clk) begin
    dst_pix_t want;
    if (rst) begin
      dst_if.ready <= 1'b0;
    end else begin
      if (dst_if.valid && dst_if.ready) begin
        pix_seen++;
        if (pending_pix.size() == 0) begin
          report("unexpected transfer dst_x", dst_if.dst_x, 0);
        end else begin
          want = pending_pix.pop_front();
          if (dst_if.dst_x !== want.dx) report("dst_x", dst_if.dst_x, want.dx);
          if (dst_if.dst_y !== want.dy) report("dst_y", dst_if.dst_y, want.dy);
          if (dst_if.color_out !== want.color)
            report("color_out", dst_if.color_out, want.color);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        dst_if.ready <= 1'b0;
      end else if (!long_hold_done && pix_seen >= 60) begin
        long_hold_done = 1;
        hold_left = 150;
        dst_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        hold_left = $urandom_range(10, 40);
        dst_if.ready <= 1'b0;
      end else begin
        dst_if.ready <= ($urandom_range(0, 99) < 75);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((src_if.valid && src_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (dst_if.valid && dst_if.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("palette_frame_downscaler test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire
